[rtl/core/ffss_pkg.sv]
// Package: shared constants and types for the float-to-fixed converter.
package ffss_pkg;

	localparam int unsigned DefWidth = 18;
	localparam int unsigned FloatW   = 32;
	localparam int unsigned ShiftW   = 5;
	localparam int unsigned ExpW     = 8;
	localparam int unsigned MantW    = 23;
	localparam logic [ExpW-1:0] ExpMax = 8'hFF;
	localparam logic [ExpW-1:0] ExpMin = 8'h00;

	// Decoded input, registered between the two stages.
	typedef struct packed {
		logic        neg;
		logic        zero;
		logic        sat;
		logic [ExpW-1:0] expo;
		logic [MantW:0]  sig;
		logic [ShiftW-1:0] shift;
	} dec_t;

endpackage

[rtl/core/ffss_stream_if.sv]
// Interface: valid/ready channel carrying one payload item.
interface ffss_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/ffss_convert.sv]
// Module: combinational scale, round-half-even and saturate of a decoded float.
module ffss_convert #(
	parameter int unsigned WIDTH = ffss_pkg::DefWidth
) (
	input  ffss_pkg::dec_t     dec,
	output logic [WIDTH-1:0]   fixed_value
);
	import ffss_pkg::*;

	// k = expo - 150 + WIDTH-1-shift, in a signed 11-bit range
	localparam int KW = 11;
	localparam logic signed [KW-1:0] KBias = KW'(150 - (int'(WIDTH) - 1));

	logic signed [KW-1:0] k;
	logic [KW-1:0]        r;
	logic [63:0]          ext;
	logic [63:0]          mag;
	logic [63:0]          rem;
	logic [63:0]          halfw;
	logic [63:0]          lim_pos;
	logic [63:0]          lim_neg;
	logic                 big;
	logic                 tiny;
	logic [WIDTH-1:0]     sat_code;

	always_comb begin
		k = $signed({3'b000, dec.expo}) - KBias - $signed({6'd0, dec.shift});
		r = -k;
		ext = {40'd0, dec.sig};
		big = 1'b0;
		tiny = 1'b0;
		rem = '0;
		halfw = '0;
		lim_pos = (64'd1 << (WIDTH - 1)) - 64'd1;
		lim_neg = 64'd1 << (WIDTH - 1);
		mag = '0;
		if (k >= 0) begin
			if (k >= KW'(40)) big = 1'b1;
			else mag = ext << k[5:0];
		end else begin
			if (r >= KW'(26)) tiny = 1'b1;
			else begin
				mag = ext >> r[4:0];
				rem = ext & ((64'd1 << r[4:0]) - 64'd1);
				halfw = 64'd1 << (r[4:0] - 5'd1);
				if (rem > halfw || (rem == halfw && mag[0])) mag = mag + 64'd1;
			end
		end
		sat_code = dec.neg ? {1'b1, {(WIDTH-1){1'b0}}} : {1'b0, {(WIDTH-1){1'b1}}};
		if (dec.zero || tiny) fixed_value = '0;
		else if (dec.sat || big) fixed_value = sat_code;
		else if (dec.neg) begin
			if (mag > lim_neg) fixed_value = sat_code;
			else fixed_value = WIDTH'(64'd0 - mag);
		end else begin
			if (mag > lim_pos) fixed_value = sat_code;
			else fixed_value = mag[WIDTH-1:0];
		end
	end
endmodule

[rtl/core/float_to_fixed_shift_saturating_top.sv]
// Top level: float32 to signed fixed-point converter with saturation.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------
//  in_ch    | in  | float_bits[31:0], int_shift[4:0]
//  out_ch   | out | fixed_value[WIDTH-1:0] signed
//
// One item per cycle sustained while out_ch does not stall; the path runs through
// the decode register, then the result register. The shift, round and clamp sit between them.
// arst_n clears the valid flags only; payload registers are not reset.
// A stall on out_ch holds the result register; in_ch stays ready while either
// stage is empty or the result is taken in the same cycle.
module float_to_fixed_shift_saturating_top #(
	parameter int unsigned WIDTH = ffss_pkg::DefWidth
) (
	input logic clk,
	input logic arst_n,
	ffss_stream_if.sink   in_ch,
	ffss_stream_if.source out_ch
);
	import ffss_pkg::*;

	dec_t             dec_s1;
	logic             vld_s1;
	logic             vld_s2;
	logic [WIDTH-1:0] res_s2;
	logic [WIDTH-1:0] conv;
	logic             adv_s2;
	logic             adv_s1;
	logic [FloatW-1:0] fb;

	// advance stage 2 when empty or taken; stage 1 when stage 2 can take it
	assign adv_s2 = !vld_s2 || out_ch.ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ch.ready = adv_s1;
	assign fb = in_ch.data.float_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_ch.valid;
		end
	end

	// decode: flag zero/NaN/bad shift and infinity up front
	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			dec_s1.neg   <= fb[31];
			dec_s1.expo  <= fb[30:23];
			dec_s1.sig   <= {1'b1, fb[22:0]};
			dec_s1.shift <= in_ch.data.int_shift;
			dec_s1.zero  <= (32'(in_ch.data.int_shift) > WIDTH - 1)
				|| (fb[30:23] == ExpMin)
				|| (fb[30:23] == ExpMax && fb[22:0] != '0);
			dec_s1.sat   <= (fb[30:23] == ExpMax);
		end
	end

	ffss_convert #(.WIDTH(WIDTH)) u_conv (
		.dec         (dec_s1),
		.fixed_value (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= conv;
		end
	end

	assign out_ch.valid = vld_s2;
	assign out_ch.data.fixed_value = res_s2;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !out_ch.ready |=> vld_s2 && $stable(res_s2))
		else $error("result dropped under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s2 |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> vld_s2)
		else $error("item lost between stages");
`endif
endmodule
